// ----- sv/rlfe_pkg.sv -----
// Shared types and fixed field widths for the RGB linear fade engine.
`default_nettype none

package rlfe_pkg;

    localparam int CHAN_W    = 8;
    localparam int TIME_W    = 11;
    localparam int NUM_LANES = 3;
    localparam int IN_W      = 40;
    localparam int OUT_W     = NUM_LANES * CHAN_W;

    typedef struct packed {
        logic load;
        logic div_step;
        logic step;
        logic jump;
    } t_lane_cmd;

endpackage

`default_nettype wire

// ----- sv/rlfe_step_search.sv -----
// Step count from the fade time by reciprocal multiplication, saturated at the maximum step count.
`default_nettype none

module rlfe_step_search #(
    parameter int UPDATE_PERIOD_MS = 20,
    parameter int MAX_STEPS        = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [rlfe_pkg::TIME_W-1:0]      i_time_ms,
    output logic                             o_done,
    output logic [$clog2(MAX_STEPS+1)-1:0]   o_steps
);

    localparam int STEP_W   = $clog2(MAX_STEPS + 1);
    localparam int RECIP_SH = rlfe_pkg::TIME_W + $clog2(UPDATE_PERIOD_MS);
    localparam int RECIP    = ((1 << RECIP_SH) + UPDATE_PERIOD_MS - 1) / UPDATE_PERIOD_MS;
    localparam int RECIP_W  = rlfe_pkg::TIME_W + 1;
    localparam int PROD_W   = rlfe_pkg::TIME_W + RECIP_W;
    localparam int QUO_W    = PROD_W - RECIP_SH;
    localparam int CW       = (QUO_W > STEP_W) ? QUO_W : STEP_W;

    logic [STEP_W-1:0]           r_steps;
    logic                        r_done;
    logic [PROD_W-1:0]           prod;
    logic [QUO_W-1:0]            quo;
    logic                        over;

    // The reciprocal is rounded up with enough fraction bits to give the exact
    // truncated quotient for every fade time that fits the field.
    assign prod = PROD_W'(i_time_ms) * PROD_W'(RECIP);
    assign quo  = prod[PROD_W-1:RECIP_SH];
    assign over = (CW'(quo) > CW'(MAX_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_steps <= over ? STEP_W'(MAX_STEPS) : STEP_W'(quo);
        end
    end

    assign o_done  = r_done;
    assign o_steps = r_steps;

endmodule

`default_nettype wire

// ----- sv/rlfe_lane.sv -----
// One color channel: increment divider, fixed-point accumulator and current level.
`default_nettype none

module rlfe_lane #(
    parameter int FRACTION_BITS = 8,
    parameter int STEP_W        = 7
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  rlfe_pkg::t_lane_cmd              i_cmd,
    input  wire  [rlfe_pkg::CHAN_W-1:0]      i_target,
    input  wire  [STEP_W-1:0]                i_steps,
    output logic [rlfe_pkg::CHAN_W-1:0]      o_step_level
);

    localparam int CW = rlfe_pkg::CHAN_W;
    localparam int QW = CW + FRACTION_BITS;

    logic [CW-1:0]     r_cur;
    logic [QW-1:0]     r_acc;
    logic [QW-1:0]     r_quo;
    logic [QW-1:0]     r_dvd;
    logic [STEP_W:0]   r_rem;
    logic              r_neg;

    logic [CW:0]       diff;
    logic [CW:0]       neg_diff;
    logic [CW-1:0]     mag;
    logic [STEP_W:0]   rem_sh;
    logic              ge;
    logic signed [QW:0] inc;
    logic signed [QW:0] acc_sum;
    logic [QW-1:0]     acc_next;

    assign diff     = {1'b0, i_target} - {1'b0, r_cur};
    assign neg_diff = -diff;
    assign mag      = diff[CW] ? neg_diff[CW-1:0] : diff[CW-1:0];

    assign rem_sh = {r_rem[STEP_W-1:0], r_dvd[QW-1]};
    assign ge     = (rem_sh >= {1'b0, i_steps});

    assign inc      = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign acc_sum  = $signed({1'b0, r_acc}) + inc;
    assign acc_next = acc_sum[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_acc <= '0;
            r_quo <= '0;
            r_neg <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_neg <= diff[CW];
                r_quo <= '0;
                r_acc <= {r_cur, {FRACTION_BITS{1'b0}}};
            end else if (i_cmd.div_step) begin
                r_quo <= {r_quo[QW-2:0], ge};
            end else if (i_cmd.step) begin
                r_acc <= acc_next;
                r_cur <= acc_next[QW-1:FRACTION_BITS];
            end else if (i_cmd.jump) begin
                r_cur <= i_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd <= {mag, {FRACTION_BITS{1'b0}}};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= ge ? (rem_sh - {1'b0, i_steps}) : rem_sh;
        end
    end

    assign o_step_level = acc_next[QW-1:FRACTION_BITS];

endmodule

`default_nettype wire

// ----- sv/rgb_linear_fade_engine_core.sv -----
// Top level of the RGB linear fade engine: control sequencer, three lanes and output stage.
//
// The slave channel takes one beat per fade: target red, green and blue and the fade
// time in milliseconds. The fade time divided by the update period, saturated at
// MAX_STEPS, gives the step count. The block then sends that many colors on the
// master channel, with tlast on the final one; a step count of zero sends nothing.
// With fading disabled through the configuration port, the target is sent once as
// a single beat with tlast set.
// Each accepted beat first finds the step count in a registered search, the fade
// time multiplied by a fixed reciprocal of the update period. The three lanes then
// divide their color differences in parallel, one quotient bit per cycle, and
// finally one color leaves per cycle while the receiver is ready. The next slave
// beat is taken once the last color of the run sits in the output register. When
// the receiver stalls, the output register holds its beat and the lanes wait; no
// color is lost. Reset clears the current color to black, empties the output
// register and enables fading.
`default_nettype none

module rgb_linear_fade_engine_core #(
    parameter int UPDATE_PERIOD_MS = 20,
    parameter int MAX_STEPS        = 64,
    parameter int FRACTION_BITS    = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_wdata,
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // target_red, target_green, target_blue, fade_time_ms, zero fill
    input  wire  [rlfe_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    // red_level, green_level, blue_level
    output logic [rlfe_pkg::OUT_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);

    localparam int CW      = rlfe_pkg::CHAN_W;
    localparam int LANES   = rlfe_pkg::NUM_LANES;
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int QW      = CW + FRACTION_BITS;
    localparam int CNT_MAX = (QW > MAX_STEPS) ? QW : MAX_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_EMIT,
        ST_JUMP
    } t_state;

    t_state                  r_state;
    logic                    r_fade_en;
    logic [CNT_W-1:0]        r_cnt;
    logic [CW-1:0]           r_target [LANES];
    logic                    r_out_valid;
    logic [rlfe_pkg::OUT_W-1:0] r_out_data;
    logic                    r_out_last;

    rlfe_pkg::t_lane_cmd     cmd;
    logic                    s_accept;
    logic                    out_space;
    logic                    search_start;
    logic                    search_done;
    logic [STEP_W-1:0]       steps;
    logic [CW-1:0]           step_level [LANES];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_space       = !r_out_valid || i_m_axis_tready;
    assign search_start    = s_accept && r_fade_en;

    always_comb begin
        cmd          = '0;
        cmd.load     = (r_state == ST_SEARCH) && search_done && (steps != '0);
        cmd.div_step = (r_state == ST_DIVIDE);
        cmd.step     = (r_state == ST_EMIT) && out_space;
        cmd.jump     = (r_state == ST_JUMP) && out_space;
    end

    rlfe_step_search #(
        .UPDATE_PERIOD_MS (UPDATE_PERIOD_MS),
        .MAX_STEPS        (MAX_STEPS)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (search_start),
        .i_time_ms (i_s_axis_tdata[3*CW +: rlfe_pkg::TIME_W]),
        .o_done    (search_done),
        .o_steps   (steps)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rlfe_lane #(
            .FRACTION_BITS (FRACTION_BITS),
            .STEP_W        (STEP_W)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_target     (r_target[g]),
            .i_steps      (steps),
            .o_step_level (step_level[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int c = 0; c < LANES; c++) begin
                r_target[c] <= i_s_axis_tdata[c*CW +: CW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_fade_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_data  <= '0;
        end else begin
            if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_state <= r_fade_en ? ST_SEARCH : ST_JUMP;
                    end
                end
                ST_SEARCH: begin
                    if (search_done) begin
                        if (steps == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIVIDE;
                            r_cnt   <= CNT_W'(QW);
                        end
                    end
                end
                ST_DIVIDE: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_EMIT;
                        r_cnt   <= CNT_W'(steps);
                    end
                end
                ST_EMIT: begin
                    if (out_space) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= (r_cnt == CNT_W'(1));
                        for (int c = 0; c < LANES; c++) begin
                            r_out_data[c*CW +: CW] <= step_level[c];
                        end
                        r_cnt <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_JUMP: begin
                    if (out_space) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= 1'b1;
                        for (int c = 0; c < LANES; c++) begin
                            r_out_data[c*CW +: CW] <= r_target[c];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_last_step_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && (r_cnt == CNT_W'(1))) |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("Final step of a run was not sent with tlast.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("Slave channel stayed ready after taking a beat.");

    a_divide_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE || r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("Cycle counter ran out while dividing or emitting.");

    a_lane_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.step, cmd.jump}))
        else $error("More than one lane command issued in a cycle.");
`endif

endmodule

`default_nettype wire
